### src/sip4_pkg.sv
// Package for the 4x4 intra subblock predictor.
// Holds the submode codes and the request and result payload types.
// No dependencies.
`default_nettype none

package sip4_pkg;

  // Prediction submodes; codes above SM_HU are invalid
  typedef enum logic [3:0] {
    SM_DC = 4'd0,
    SM_TM = 4'd1,
    SM_VE = 4'd2,
    SM_HE = 4'd3,
    SM_LD = 4'd4,
    SM_RD = 4'd5,
    SM_VR = 4'd6,
    SM_VL = 4'd7,
    SM_HD = 4'd8,
    SM_HU = 4'd9
  } submode_t;

  localparam int unsigned PixMax = 255;

  // One prediction request: submode and edge pixels
  typedef struct packed {
    logic [3:0]  submode;
    logic [7:0]  corner_pixel;
    logic [63:0] above_row;
    logic [31:0] left_column;
  } req_t;

  // One predicted 4x4 block, column j of each row in byte j
  typedef struct packed {
    logic [31:0] row_zero;
    logic [31:0] row_one;
    logic [31:0] row_two;
    logic [31:0] row_three;
    logic        bad_submode;
  } res_t;

endpackage

`default_nettype wire

### src/sip4_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on sip4_pkg for the payload types.
`default_nettype none

interface sip4_req_if;
  logic              valid;
  logic              ready;
  sip4_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sip4_res_if;
  logic              valid;
  logic              ready;
  sip4_pkg::res_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/subblock_intra_predictor_4x4.sv
// 4x4 intra subblock predictor: input register, prediction logic, result register.
// Depends on sip4_pkg and the channel interfaces in sip4_if.sv.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------------
//   req     | in  | submode, corner_pixel, above_row, left_column
//   res     | out | row_zero, row_one, row_two, row_three, bad_submode
//
// One request per cycle sustained while the result side keeps up; a request
// passes through the input register, then the result register, before its
// result is offered.
// rst clears only the two stage valid bits; the data registers have no reset.
// A stalled result holds in the result register while one more request
// waits in the input register; req.ready drops only when both are full.
`default_nettype none

module subblock_intra_predictor_4x4 (
  input  wire logic  clk,
  input  wire logic  rst,
  sip4_req_if.sink   req,
  sip4_res_if.source res
);

  logic              in_vld;
  sip4_pkg::req_t    in_q;
  logic              out_vld;
  sip4_pkg::res_t    out_q;
  logic              out_adv;
  logic              in_adv;

  logic [7:0]        e [0:12];
  logic [7:0]        c3 [1:11];
  logic [7:0]        t2 [0:8];
  logic [7:0]        s_left;
  logic [7:0]        s_above;
  logic [10:0]       dc_sum;
  logic [3:0][3:0][7:0] b;
  logic              bad;
  sip4_pkg::res_t    res_next;

  // Advance when the next stage is empty or draining
  assign out_adv   = !out_vld || res.ready;
  assign in_adv    = !in_vld || out_adv;
  assign req.ready = in_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_adv) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && req.valid) begin
      in_q <= req.data;
    end
  end

  // Edge line: L3..L0, corner, A0..A7
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e[3 - i] = in_q.left_column[8*i +: 8];
    end
    e[4] = in_q.corner_pixel;
    for (int i = 0; i < 8; i++) begin
      e[5 + i] = in_q.above_row[8*i +: 8];
    end
  end

  // 3-tap and 2-tap averages along the edge line
  always_comb begin
    for (int k = 1; k < 12; k++) begin
      c3[k] = 8'(({2'b00, e[k-1]} + {1'b0, e[k], 1'b0} + {2'b00, e[k+1]} + 10'd2) >> 2);
    end
    for (int k = 0; k < 9; k++) begin
      t2[k] = 8'(({1'b0, e[k]} + {1'b0, e[k+1]} + 9'd1) >> 1);
    end
    // Edge repeated past the last left pixel and the last above pixel
    s_left  = 8'(({2'b00, e[1]} + {1'b0, e[0], 1'b0} + {2'b00, e[0]} + 10'd2) >> 2);
    s_above = 8'(({2'b00, e[11]} + {1'b0, e[12], 1'b0} + {2'b00, e[12]} + 10'd2) >> 2);
    dc_sum = 11'd4;
    for (int i = 0; i < 4; i++) begin
      dc_sum = dc_sum + {3'b000, e[i]} + {3'b000, e[5 + i]};
    end
  end

  // Build the predicted block for the registered submode
  always_comb begin
    logic signed [9:0] tm;
    b   = '0;
    bad = 1'b0;
    tm  = '0;
    case (sip4_pkg::submode_t'(in_q.submode))
      sip4_pkg::SM_DC: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            b[r][c] = dc_sum[10:3];
          end
        end
      end
      sip4_pkg::SM_TM: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            tm = $signed({2'b00, e[5 + c]}) + $signed({2'b00, e[3 - r]})
               - $signed({2'b00, e[4]});
            if (tm < 0) begin
              b[r][c] = 8'd0;
            end else if (tm > 10'(sip4_pkg::PixMax)) begin
              b[r][c] = 8'(sip4_pkg::PixMax);
            end else begin
              b[r][c] = tm[7:0];
            end
          end
        end
      end
      sip4_pkg::SM_VE: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            b[r][c] = c3[5 + c];
          end
        end
      end
      sip4_pkg::SM_HE: begin
        for (int c = 0; c < 4; c++) begin
          b[0][c] = c3[3];
          b[1][c] = c3[2];
          b[2][c] = c3[1];
          b[3][c] = s_left;
        end
      end
      sip4_pkg::SM_LD: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            b[r][c] = (r + c == 6) ? s_above : c3[6 + r + c];
          end
        end
      end
      sip4_pkg::SM_RD: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            b[r][c] = c3[4 + c - r];
          end
        end
      end
      sip4_pkg::SM_VR: begin
        b[3][0] = c3[2];
        b[2][0] = c3[3];
        b[3][1] = c3[4];  b[1][0] = c3[4];
        b[2][1] = t2[4];  b[0][0] = t2[4];
        b[3][2] = c3[5];  b[1][1] = c3[5];
        b[2][2] = t2[5];  b[0][1] = t2[5];
        b[3][3] = c3[6];  b[1][2] = c3[6];
        b[2][3] = t2[6];  b[0][2] = t2[6];
        b[1][3] = c3[7];
        b[0][3] = t2[7];
      end
      sip4_pkg::SM_VL: begin
        b[0][0] = t2[5];
        b[1][0] = c3[6];
        b[2][0] = t2[6];  b[0][1] = t2[6];
        b[1][1] = c3[7];  b[3][0] = c3[7];
        b[2][1] = t2[7];  b[0][2] = t2[7];
        b[3][1] = c3[8];  b[1][2] = c3[8];
        b[0][3] = t2[8];  b[2][2] = t2[8];
        b[1][3] = c3[9];  b[3][2] = c3[9];
        b[2][3] = c3[10];
        b[3][3] = c3[11];
      end
      sip4_pkg::SM_HD: begin
        b[3][0] = t2[0];
        b[3][1] = c3[1];
        b[2][0] = t2[1];  b[3][2] = t2[1];
        b[2][1] = c3[2];  b[3][3] = c3[2];
        b[2][2] = t2[2];  b[1][0] = t2[2];
        b[2][3] = c3[3];  b[1][1] = c3[3];
        b[1][2] = t2[3];  b[0][0] = t2[3];
        b[1][3] = c3[4];  b[0][1] = c3[4];
        b[0][2] = c3[5];
        b[0][3] = c3[6];
      end
      sip4_pkg::SM_HU: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            b[r][c] = e[0];
          end
        end
        b[0][0] = t2[2];
        b[0][1] = c3[2];
        b[0][2] = t2[1];  b[1][0] = t2[1];
        b[0][3] = c3[1];  b[1][1] = c3[1];
        b[1][2] = t2[0];  b[2][0] = t2[0];
        b[1][3] = s_left; b[2][1] = s_left;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    res_next.row_zero    = b[0];
    res_next.row_one     = b[1];
    res_next.row_two     = b[2];
    res_next.row_three   = b[3];
    res_next.bad_submode = bad;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_vld) begin
      out_q <= res_next;
    end
  end

  assign res.valid = out_vld;
  assign res.data  = out_q;

  // An invalid submode yields an all-zero block
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_q.bad_submode |-> (out_q.row_zero == '0) && (out_q.row_one == '0)
      && (out_q.row_two == '0) && (out_q.row_three == '0))
    else $error("invalid submode gave a nonzero block");

  // Back-pressure only when both stages hold a request
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> in_vld && out_vld && !res.ready)
    else $error("request side stalled with room in the pipeline");

  // A request leaving the input stage lands in the result stage
  a_move: assert property (@(posedge clk) disable iff (rst)
    in_vld && out_adv |=> out_vld)
    else $error("request lost between stages");

  // Without a new request, a drained input stage is empty next cycle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    in_adv && !req.valid |=> !in_vld)
    else $error("input stage valid without a request");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for subblock_intra_predictor_4x4: random bursts of prediction
// requests against a stalling result sink, each block checked against a local predictor.
// Depends on sip4_pkg, the channel interfaces in sip4_if.sv and the predictor RTL.

module testbench;

  localparam int ClkHalf = 4;
  localparam int RandomItems = 1100;
  localparam int DrainCycles = 8;
  localparam int LimitCycles = 400000;
  localparam int MaxReports = 40;
  localparam int HoldCycles = 60;

  logic clk;
  logic rst;

  sip4_req_if req_ch ();
  sip4_res_if res_ch ();

  subblock_intra_predictor_4x4 dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  sip4_pkg::req_t pending_reqs[$];
  sip4_pkg::res_t predicted_blocks[$];
  sip4_pkg::res_t want_block;
  logic req_taken;
  int total_reqs;
  int accepted_count;
  int checked_count;
  int error_count;
  int input_stalls;
  int mode_hits[16];
  int gap_left;
  int burst_left;
  int cycle_count;
  int hold_left;
  int stall_mode;
  int mode_left;

  // Averages used by the diagonal and smoothed modes
  function automatic int unsigned mean2(int unsigned a, int unsigned b);
    return (a + b + 1) >> 1;
  endfunction

  function automatic int unsigned mean3(int unsigned a, int unsigned b, int unsigned c);
    return (a + 2 * b + c + 2) >> 2;
  endfunction

  // 3-tap smoothing centered on border[k]
  function automatic int unsigned tap3(int unsigned border[13], int k);
    return mean3(border[k - 1], border[k], border[k + 1]);
  endfunction

  // Compute the 4x4 predicted block for one request
  function automatic sip4_pkg::res_t predict_block(sip4_pkg::req_t rq);
    int unsigned border[13];
    int unsigned top[8];
    int unsigned lft[4];
    int unsigned blk[4][4];
    int unsigned p;
    int unsigned dc_sum;
    int tm;
    int r;
    int c;
    int i;
    logic [31:0] rows[4];
    sip4_pkg::res_t out;
    p = rq.corner_pixel;
    for (i = 0; i < 8; i++) top[i] = rq.above_row[8*i +: 8];
    for (i = 0; i < 4; i++) lft[i] = rq.left_column[8*i +: 8];
    // border line runs L3..L0, corner, A0..A7
    for (i = 0; i < 4; i++) border[3 - i] = lft[i];
    border[4] = p;
    for (i = 0; i < 8; i++) border[5 + i] = top[i];
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++) blk[r][c] = 0;

    case (rq.submode)
      sip4_pkg::SM_DC: begin
        dc_sum = 4;
        for (i = 0; i < 4; i++) dc_sum += top[i] + lft[i];
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) blk[r][c] = dc_sum >> 3;
      end
      sip4_pkg::SM_TM: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) begin
            tm = int'(top[c]) + int'(lft[r]) - int'(p);
            if (tm < 0) tm = 0;
            if (tm > int'(sip4_pkg::PixMax)) tm = sip4_pkg::PixMax;
            blk[r][c] = tm;
          end
      end
      sip4_pkg::SM_VE: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) blk[r][c] = tap3(border, 5 + c);
      end
      sip4_pkg::SM_HE: begin
        // bottom row repeats L3 below the block
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++)
            blk[r][c] = (r == 3) ? mean3(lft[2], lft[3], lft[3]) : tap3(border, 3 - r);
      end
      sip4_pkg::SM_LD: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++)
            blk[r][c] = (r + c == 6) ? mean3(top[6], top[7], top[7])
                                     : tap3(border, 5 + r + c + 1);
      end
      sip4_pkg::SM_RD: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) blk[r][c] = tap3(border, 4 + c - r);
      end
      sip4_pkg::SM_VR: begin
        blk[3][0] = tap3(border, 2);
        blk[2][0] = tap3(border, 3);
        blk[3][1] = tap3(border, 4);
        blk[1][0] = blk[3][1];
        blk[2][1] = mean2(border[4], border[5]);
        blk[0][0] = blk[2][1];
        blk[3][2] = tap3(border, 5);
        blk[1][1] = blk[3][2];
        blk[2][2] = mean2(border[5], border[6]);
        blk[0][1] = blk[2][2];
        blk[3][3] = tap3(border, 6);
        blk[1][2] = blk[3][3];
        blk[2][3] = mean2(border[6], border[7]);
        blk[0][2] = blk[2][3];
        blk[1][3] = tap3(border, 7);
        blk[0][3] = mean2(border[7], border[8]);
      end
      sip4_pkg::SM_VL: begin
        blk[0][0] = mean2(top[0], top[1]);
        blk[1][0] = mean3(top[0], top[1], top[2]);
        blk[2][0] = mean2(top[1], top[2]);
        blk[0][1] = blk[2][0];
        blk[1][1] = mean3(top[1], top[2], top[3]);
        blk[3][0] = blk[1][1];
        blk[2][1] = mean2(top[2], top[3]);
        blk[0][2] = blk[2][1];
        blk[3][1] = mean3(top[2], top[3], top[4]);
        blk[1][2] = blk[3][1];
        blk[0][3] = mean2(top[3], top[4]);
        blk[2][2] = blk[0][3];
        blk[1][3] = mean3(top[3], top[4], top[5]);
        blk[3][2] = blk[1][3];
        blk[2][3] = mean3(top[4], top[5], top[6]);
        blk[3][3] = mean3(top[5], top[6], top[7]);
      end
      sip4_pkg::SM_HD: begin
        blk[3][0] = mean2(border[0], border[1]);
        blk[3][1] = tap3(border, 1);
        blk[2][0] = mean2(border[1], border[2]);
        blk[3][2] = blk[2][0];
        blk[2][1] = tap3(border, 2);
        blk[3][3] = blk[2][1];
        blk[2][2] = mean2(border[2], border[3]);
        blk[1][0] = blk[2][2];
        blk[2][3] = tap3(border, 3);
        blk[1][1] = blk[2][3];
        blk[1][2] = mean2(border[3], border[4]);
        blk[0][0] = blk[1][2];
        blk[1][3] = tap3(border, 4);
        blk[0][1] = blk[1][3];
        blk[0][2] = tap3(border, 5);
        blk[0][3] = tap3(border, 6);
      end
      sip4_pkg::SM_HU: begin
        // lower right fills with L3
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) blk[r][c] = lft[3];
        blk[0][0] = mean2(lft[0], lft[1]);
        blk[0][1] = mean3(lft[0], lft[1], lft[2]);
        blk[0][2] = mean2(lft[1], lft[2]);
        blk[1][0] = blk[0][2];
        blk[0][3] = mean3(lft[1], lft[2], lft[3]);
        blk[1][1] = blk[0][3];
        blk[1][2] = mean2(lft[2], lft[3]);
        blk[2][0] = blk[1][2];
        blk[1][3] = mean3(lft[2], lft[3], lft[3]);
        blk[2][1] = blk[1][3];
      end
      default: begin
      end
    endcase

    // Pack column c of each row into byte c
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++) rows[r][8*c +: 8] = blk[r][c][7:0];
    out.row_zero = rows[0];
    out.row_one = rows[1];
    out.row_two = rows[2];
    out.row_three = rows[3];
    out.bad_submode = (rq.submode > sip4_pkg::SM_HU);
    return out;
  endfunction

  // Queue one request for the driver
  task automatic add_req(logic [3:0] mode, logic [7:0] p, logic [63:0] above,
                         logic [31:0] left);
    sip4_pkg::req_t rq;
    rq.submode = mode;
    rq.corner_pixel = p;
    rq.above_row = above;
    rq.left_column = left;
    pending_reqs.push_back(rq);
  endtask

  // Pixel with extra weight on the ends of the range
  function automatic logic [7:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // Flag and report one field mismatch
  task automatic compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
    end
  endtask

  // Clock and reset
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    fork
      forever #ClkHalf clk = ~clk;
      begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst = 1'b0;
      end
    join_none
  end

  // Drive requests in bursts with random gaps; hold until the request is taken
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else if (!req_ch.valid || req_taken) begin
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        req_ch.data <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Result sink: stall pattern switches now and then, plus two long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      cycle_count = 0;
      hold_left = 0;
      stall_mode = 0;
      mode_left = 0;
    end else begin
      cycle_count++;
      if (cycle_count == 200 || cycle_count == 900) hold_left = HoldCycles;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= cycle_count[0];
        endcase
      end
    end
  end

  // Predict on each taken request; check each taken result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        predicted_blocks.push_back(predict_block(req_ch.data));
        accepted_count++;
        mode_hits[req_ch.data.submode]++;
      end
      if (req_ch.valid && !req_ch.ready) input_stalls++;
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_blocks.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: result with no request outstanding: expected none, actual %h",
                     $time, res_ch.data);
        end else begin
          want_block = predicted_blocks.pop_front();
          compare_field("row_zero", want_block.row_zero, res_ch.data.row_zero);
          compare_field("row_one", want_block.row_one, res_ch.data.row_one);
          compare_field("row_two", want_block.row_two, res_ch.data.row_two);
          compare_field("row_three", want_block.row_three, res_ch.data.row_three);
          compare_field("bad_submode", 32'(want_block.bad_submode),
                        32'(res_ch.data.bad_submode));
          checked_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int m;
    int n;
    int valid_modes;
    logic [63:0] above;
    logic [31:0] left;
    logic [3:0] mode;
    // every submode with saturated edges, then with a checkerboard of extremes
    for (m = sip4_pkg::SM_DC; m <= sip4_pkg::SM_HU; m++)
      add_req(4'(m), 8'hff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    for (m = sip4_pkg::SM_DC; m <= sip4_pkg::SM_HU; m++)
      add_req(4'(m), 8'h55, 64'hff00_ff00_00ff_00ff, 32'h00ff_ff00);
    // all-zero edges
    add_req(sip4_pkg::SM_DC, 8'h00, 64'h0, 32'h0);
    // true-motion clamping at both ends
    add_req(sip4_pkg::SM_TM, 8'hff, 64'h0, 32'h0);
    add_req(sip4_pkg::SM_TM, 8'h00, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    // invalid submodes at both ends of their range
    add_req(4'd10, 8'hff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    add_req(4'd15, 8'hff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);

    for (n = 0; n < RandomItems; n++) begin
      mode = ($urandom_range(0, 99) < 92) ? 4'($urandom_range(0, 9))
                                          : 4'($urandom_range(10, 15));
      for (m = 0; m < 8; m++) above[8*m +: 8] = rand_pixel();
      for (m = 0; m < 4; m++) left[8*m +: 8] = rand_pixel();
      add_req(mode, rand_pixel(), above, left);
    end
    total_reqs = pending_reqs.size();

    wait (accepted_count == total_reqs && checked_count == accepted_count);
    repeat (DrainCycles) @(posedge clk);

    valid_modes = 0;
    for (m = 0; m < 10; m++) valid_modes += mode_hits[m];
    $display("Checked %0d predicted blocks: %0d across the ten submodes, %0d invalid submodes.",
             checked_count, valid_modes, checked_count - valid_modes);
    $display("Request side stalled %0d cycles under result back-pressure; %0d mismatches.",
             input_stalls, error_count);
    if (error_count == 0 && predicted_blocks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (predicted_blocks.size() != 0)
        $display("%0t: %0d predicted blocks never arrived", $time, predicted_blocks.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LimitCycles * 2 * ClkHalf);
    $display("%0t: timeout, %0d of %0d requests taken, %0d results checked",
             $time, accepted_count, total_reqs, checked_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
